// ----- design/tsm_pkg.sv -----
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared types and constants of the timestamp-ordered stream merger: source
// count, field widths, status codes and the structs that travel along the
// chain of source cells.
// ----------------------------------------------------------------------------
package tsm_pkg;

    localparam int NUM_SOURCES = 8;
    localparam int SRC_W       = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int CNT_W       = ($clog2(NUM_SOURCES + 1) > 4) ? $clog2(NUM_SOURCES + 1) : 4;

    localparam int FUNC_W      = 1;
    localparam int SOURCE_W    = 3;
    localparam int TIME_W      = 64;
    localparam int BOARD_W     = 8;
    localparam int CHAN_W      = 6;
    localparam int ENERGY_W    = 16;
    localparam int FLAGS_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 4;

    localparam int PAYLOAD_W   = SOURCE_W + TIME_W + BOARD_W + CHAN_W
                               + 2 * ENERGY_W + FLAGS_W;
    localparam int TDATA_W     = ((PAYLOAD_W + 7) / 8) * 8;
    localparam int PAD_W       = TDATA_W - PAYLOAD_W;

    localparam logic [FUNC_W-1:0] FUNC_HIT = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_END = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_HIT      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_COMPLETE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REJECT   = 2'd2;

    localparam logic [0:0] REG_SOURCES_IN_USE = 1'b0;

    typedef struct packed {
        logic [TIME_W-1:0]   hit_time;
        logic [BOARD_W-1:0]  board;
        logic [CHAN_W-1:0]   chan;
        logic [ENERGY_W-1:0] energy_long;
        logic [ENERGY_W-1:0] energy_short;
        logic [FLAGS_W-1:0]  flags;
    } hit_t;

    // Running verdict of a scan as it walks from cell to cell.
    typedef struct packed {
        logic             tok;
        logic             live;
        logic             full;
        logic             found;
        logic [SRC_W-1:0] idx;
        hit_t             hit;
    } cand_t;

    typedef struct packed {
        logic in_use;
        logic set_head;
        logic set_end;
        logic release_head;
        logic rearm;
    } cell_ctl_t;

endpackage

// ----- design/timestamp_ordered_stream_merger.sv -----
// ----------------------------------------------------------------------------
// timestamp_ordered_stream_merger
// Merges hit streams of up to NUM_SOURCES sources into one stream ordered by
// timestamp, with run-complete and reject reporting.
// ----------------------------------------------------------------------------
// Each source owns one cell in a chain that holds its pending head hit. An
// accepted hit or end mark is written into its cell, then a scan token walks
// the chain one cell per cycle, carrying the earliest head seen so far (ties
// go to the lower source). The input takes no new request until the walk
// through the chain has ended; a rejected request skips the walk and goes
// straight to its reject result.
// The result sits in an output register, so the next request is taken while
// it waits; a new result that finds the output register still occupied waits
// until the receiver takes the older one, and the input stalls meanwhile.
// Writing sources_in_use starts a new run.
module timestamp_ordered_stream_merger
    import tsm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // s_tdata, from bit 0: source, hit_time, board, chan, energy_long,
    // energy_gate_short, hit_flags, zero padding.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [TDATA_W-1:0]  s_tdata,
    // s_tuser: func.
    input  logic [FUNC_W-1:0]   s_tuser,
    // m_tdata, from bit 0: from_source, out_time, out_board, out_chan,
    // out_energy_long, out_energy_short, out_flags, zero padding.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,
    // m_tuser: status.
    output logic [STATUS_W-1:0] m_tuser,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LAUNCH = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]    cfg_reg;
    logic                cfg_wr;
    logic [CNT_W-1:0]    n_active;

    logic [SOURCE_W-1:0] in_source;
    logic [CNT_W-1:0]    in_source_ext;
    hit_t                in_hit;
    logic                in_accept;
    logic                in_reject;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SOURCE_W-1:0] res_src_reg, res_src_next;
    logic [SRC_W-1:0]    res_idx_reg, res_idx_next;
    hit_t                res_hit_reg, res_hit_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]  m_tdata_reg;
    logic [STATUS_W-1:0] m_tuser_reg;
    logic                out_load;

    logic [NUM_SOURCES-1:0] src_sel;
    logic [NUM_SOURCES-1:0] rel_sel;
    logic [NUM_SOURCES-1:0] present_vec;
    logic [NUM_SOURCES-1:0] ended_vec;
    cell_ctl_t              ctl [NUM_SOURCES];
    cand_t                  scan_entry;
    cand_t                  chain [NUM_SOURCES+1];
    cand_t                  scan_res;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SOURCES_IN_USE);
    assign prdata = (paddr[2] == REG_SOURCES_IN_USE) ? {{(32-CFG_W){1'b0}}, cfg_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_W'(8);
        end else if (cfg_wr) begin
            cfg_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        if (CNT_W'(cfg_reg) == '0) begin
            n_active = CNT_W'(1);
        end else if (CNT_W'(cfg_reg) > CNT_W'(NUM_SOURCES)) begin
            n_active = CNT_W'(NUM_SOURCES);
        end else begin
            n_active = CNT_W'(cfg_reg);
        end
    end

    // Input unpacking.
    assign in_source             = s_tdata[SOURCE_W-1:0];
    assign in_source_ext         = CNT_W'(in_source);
    assign in_hit.hit_time       = s_tdata[66:3];
    assign in_hit.board          = s_tdata[74:67];
    assign in_hit.chan           = s_tdata[80:75];
    assign in_hit.energy_long    = s_tdata[96:81];
    assign in_hit.energy_short   = s_tdata[112:97];
    assign in_hit.flags          = s_tdata[144:113];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_reject = (in_source_ext >= n_active) || |(src_sel & (present_vec | ended_vec));

    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // Per-cell control.
    always_comb begin
        for (int i = 0; i < NUM_SOURCES; i++) begin
            src_sel[i]             = (CNT_W'(i) == in_source_ext);
            rel_sel[i]             = (SRC_W'(i) == res_idx_reg);
            ctl[i].in_use          = (CNT_W'(i) < n_active);
            ctl[i].set_head        = in_accept && !in_reject && src_sel[i]
                                     && (s_tuser == FUNC_HIT);
            ctl[i].set_end         = in_accept && !in_reject && src_sel[i]
                                     && (s_tuser == FUNC_END);
            ctl[i].release_head    = out_load && (res_status_reg == STATUS_HIT) && rel_sel[i];
            ctl[i].rearm           = cfg_wr || (out_load && (res_status_reg == STATUS_COMPLETE));
        end
    end

    // Scan entry: an empty verdict, with the token set only in the launch state.
    always_comb begin
        scan_entry      = '0;
        scan_entry.tok  = (state_reg == ST_LAUNCH);
        scan_entry.full = 1'b1;
    end

    assign chain[0] = scan_entry;

    for (genvar g = 0; g < NUM_SOURCES; g++) begin : g_cell
        tsm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl[g]),
            .wr_hit   (in_hit),
            .my_idx   (SRC_W'(g)),
            .cand_in  (chain[g]),
            .cand_out (chain[g+1]),
            .present  (present_vec[g]),
            .ended    (ended_vec[g])
        );
    end

    assign scan_res = chain[NUM_SOURCES];

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_src_next    = res_src_reg;
        res_idx_next    = res_idx_reg;
        res_hit_next    = res_hit_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (in_reject) begin
                        res_status_next = STATUS_REJECT;
                        res_src_next    = in_source;
                        res_hit_next    = '0;
                        state_next      = ST_DONE;
                    end else begin
                        state_next = ST_LAUNCH;
                    end
                end
            end
            ST_LAUNCH: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_res.tok) begin
                    if (!scan_res.live) begin
                        res_status_next = STATUS_COMPLETE;
                        res_src_next    = '0;
                        res_hit_next    = '0;
                        state_next      = ST_DONE;
                    end else if (!scan_res.full) begin
                        state_next = ST_IDLE;
                    end else begin
                        res_status_next = STATUS_HIT;
                        res_idx_next    = scan_res.idx;
                        res_src_next    = SOURCE_W'(scan_res.idx);
                        res_hit_next    = scan_res.hit;
                        state_next      = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_src_reg    <= res_src_next;
        res_idx_reg    <= res_idx_next;
        res_hit_reg    <= res_hit_next;
    end

    // Output register.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tuser_reg <= res_status_reg;
            m_tdata_reg <= {{PAD_W{1'b0}},
                            res_hit_reg.flags,
                            res_hit_reg.energy_short,
                            res_hit_reg.energy_long,
                            res_hit_reg.chan,
                            res_hit_reg.board,
                            res_hit_reg.hit_time,
                            res_src_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- design/tsm_cell.sv -----
// ----------------------------------------------------------------------------
// tsm_cell
// One source slot of the merger: holds the pending head hit and the end mark
// of its source, and folds itself into the scan verdict passing through.
// ----------------------------------------------------------------------------
module tsm_cell
    import tsm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctl_t        ctl,
    input  hit_t             wr_hit,
    input  logic [SRC_W-1:0] my_idx,
    input  cand_t            cand_in,
    output cand_t            cand_out,
    output logic             present,
    output logic             ended
);

    logic  present_reg, present_next;
    logic  ended_reg, ended_next;
    hit_t  hit_reg;
    cand_t cand_reg, cand_next;

    always_comb begin
        present_next = present_reg;
        ended_next   = ended_reg;
        if (ctl.rearm) begin
            present_next = 1'b0;
            ended_next   = 1'b0;
        end else begin
            if (ctl.set_head) begin
                present_next = 1'b1;
            end else if (ctl.release_head) begin
                present_next = 1'b0;
            end
            if (ctl.set_end) begin
                ended_next = 1'b1;
            end
        end
    end

    // A strict compare keeps an earlier (lower) source on equal timestamps.
    always_comb begin
        cand_next = cand_in;
        if (ctl.in_use && !ended_reg) begin
            cand_next.live = 1'b1;
            if (!present_reg) begin
                cand_next.full = 1'b0;
            end else if (!cand_in.found || (hit_reg.hit_time < cand_in.hit.hit_time)) begin
                cand_next.found = 1'b1;
                cand_next.idx   = my_idx;
                cand_next.hit   = hit_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg  <= 1'b0;
            ended_reg    <= 1'b0;
            cand_reg.tok <= 1'b0;
        end else begin
            present_reg <= present_next;
            ended_reg   <= ended_next;
            cand_reg    <= cand_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.set_head) begin
            hit_reg <= wr_hit;
        end
    end

    assign cand_out = cand_reg;
    assign present  = present_reg;
    assign ended    = ended_reg;

endmodule
